// ===== hw/rtl/positional_deque_list_top_assert.svh =====
// ----------------------------------------------------------------------------
// positional_deque_list_top_assert.svh
// Assertion macros used by the list engine datapath.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_DEQUE_LIST_TOP_ASSERT_SVH
`define POSITIONAL_DEQUE_LIST_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define PDL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define PDL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pdl_pkg.sv =====
// ----------------------------------------------------------------------------
// pdl_pkg
// Types, field widths and codes of the positional deque list engine.
// ----------------------------------------------------------------------------
package pdl_pkg;

    // Field widths
    localparam int MODE_W = 3;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 7;
    localparam int CNT_W  = 7;
    localparam int ST_W   = 2;
    // Width for position and count compares (holds count + 1)
    localparam int XW     = POS_W + 1;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_INS_HEAD = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_TAIL = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_POS  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REM_HEAD = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REM_TAIL = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REM_POS  = 3'd5;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_GRAB,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_COMMIT,
        S_HEAD,
        S_TAIL,
        S_TCAP,
        S_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture item and evaluate it
        logic take_rd;     // read the entry at the target slot
        logic grab;        // capture the removed value
        logic start_walk;  // set the walk index to its first slot
        logic walk_rd;     // read the walk slot and advance
        logic put;         // write the new value into the target slot
        logic commit;      // update the count
        logic head_rd;     // read the head slot
        logic tail_rd;     // read the tail slot, capture head
        logic tail_cap;    // capture tail
        logic out_load;    // load the result register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic act;         // request changes the list
        logic ins;         // request is an insert
        logic shift;       // entries must move
        logic walk_last;   // walk index is on its final slot
        logic out_busy;    // result register holds an untaken result
    } t_dp_stat;

endpackage

// ===== hw/rtl/positional_deque_list_top.sv =====
// ----------------------------------------------------------------------------
// positional_deque_list_top
// Bounded ordered list of signed 32-bit values with head, tail and
// positional insert and remove.
//
// Input channel (i_in_valid / o_in_stall) carries mode, item value and a
// 1-based position. Output channel (o_out_valid / i_out_stall) returns one
// result per item: status, removed value, count, head and tail.
// Each item is decoded; an active remove reads and captures the removed
// value, the k stored entries that move (k is at most CAPACITY - 1) are
// walked, an insert writes the new value, and every item ends with the count
// update and the head and tail fetch. Entry moves run one per cycle through
// the single-write, single-read entry memory; one item is worked at a time.
// The result register decouples the sides: a new item is taken while an
// earlier result still waits; a stalled receiver holds the engine at its
// final step only.
// Reset clears the count and the handshake state; entry contents are not
// cleared and need no sweep.
// ----------------------------------------------------------------------------
module positional_deque_list_top
    import pdl_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic        [MODE_W-1:0] i_mode,
    input  logic signed [VAL_W-1:0]  i_item_value,
    input  logic        [POS_W-1:0]  i_position,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic        [ST_W-1:0]   o_status,
    output logic signed [VAL_W-1:0]  o_removed_value,
    output logic        [CNT_W-1:0]  o_element_count,
    output logic signed [VAL_W-1:0]  o_head_value,
    output logic signed [VAL_W-1:0]  o_tail_value
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequence control
    pdl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Storage and result path
    pdl_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_mode          (i_mode),
        .i_item_value    (i_item_value),
        .i_position      (i_position),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_element_count (o_element_count),
        .o_head_value    (o_head_value),
        .o_tail_value    (o_tail_value)
    );

endmodule

// ===== hw/rtl/pdl_dp.sv =====
// ----------------------------------------------------------------------------
// pdl_dp
// Datapath: entry memory, count, request decode, shift walker and the
// result register.
// ----------------------------------------------------------------------------
`include "positional_deque_list_top_assert.svh"

module pdl_dp
    import pdl_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic        [MODE_W-1:0] i_mode,
    input  logic signed [VAL_W-1:0]  i_item_value,
    input  logic        [POS_W-1:0]  i_position,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output logic        [ST_W-1:0]   o_status,
    output logic signed [VAL_W-1:0]  o_removed_value,
    output logic        [CNT_W-1:0]  o_element_count,
    output logic signed [VAL_W-1:0]  o_head_value,
    output logic signed [VAL_W-1:0]  o_tail_value
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Entry memory
    logic [VAL_W-1:0] r_mem [CAPACITY];
    logic [VAL_W-1:0] r_rdata;

    // Control state
    logic [CW-1:0]    r_count;
    logic             r_wpend;
    logic             r_out_valid;

    // Item and walk state
    logic             r_ins;
    logic             r_act;
    logic             r_shift;
    logic [ST_W-1:0]  r_status;
    logic [VAL_W-1:0] r_value;
    logic [AW-1:0]    r_at;
    logic [AW-1:0]    r_idx;
    logic [AW-1:0]    r_wa;
    logic [VAL_W-1:0] r_removed;
    logic [VAL_W-1:0] r_head;
    logic [VAL_W-1:0] r_tail;

    // Result register payload
    logic [ST_W-1:0]  r_o_status;
    logic [VAL_W-1:0] r_o_removed;
    logic [CNT_W-1:0] r_o_count;
    logic [VAL_W-1:0] r_o_head;
    logic [VAL_W-1:0] r_o_tail;

    // Decode results
    logic [XW-1:0]    cnt_x;
    logic [XW-1:0]    pos_x;
    logic [XW-1:0]    d_at;
    logic [ST_W-1:0]  d_status;
    logic             d_act;
    logic             d_ins;
    logic             d_shift;

    // Memory port signals
    logic [AW-1:0]    tail_addr;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_data;

    assign cnt_x     = XW'(r_count);
    assign pos_x     = XW'(i_position);
    assign tail_addr = AW'(r_count - CW'(1));

    // Decode the request against the current count
    always_comb begin
        d_status = ST_OK;
        d_act    = 1'b0;
        d_ins    = 1'b0;
        d_at     = '0;
        if (i_mode inside {MODE_INS_HEAD, MODE_INS_TAIL, MODE_INS_POS}) begin
            d_ins = 1'b1;
            if (cnt_x >= XW'(CAPACITY)) begin
                d_status = ST_FULL;
            end else begin
                case (i_mode)
                    MODE_INS_HEAD: begin
                        d_act = 1'b1;
                    end
                    MODE_INS_TAIL: begin
                        d_act = 1'b1;
                        d_at  = cnt_x;
                    end
                    default: begin
                        if (pos_x >= XW'(1) && pos_x <= cnt_x + XW'(1)) begin
                            d_act = 1'b1;
                            d_at  = pos_x - XW'(1);
                        end else begin
                            d_status = ST_RANGE;
                        end
                    end
                endcase
            end
        end else if (i_mode inside {MODE_REM_HEAD, MODE_REM_TAIL, MODE_REM_POS}) begin
            if (cnt_x == '0) begin
                d_status = ST_EMPTY;
            end else begin
                case (i_mode)
                    MODE_REM_HEAD: begin
                        d_act = 1'b1;
                    end
                    MODE_REM_TAIL: begin
                        d_act = 1'b1;
                        d_at  = cnt_x - XW'(1);
                    end
                    default: begin
                        if (pos_x >= XW'(1) && pos_x <= cnt_x) begin
                            d_act = 1'b1;
                            d_at  = pos_x - XW'(1);
                        end else begin
                            d_status = ST_RANGE;
                        end
                    end
                endcase
            end
        end
        d_shift = d_ins ? (d_at != cnt_x) : (d_at != cnt_x - XW'(1));
    end

    // Select the read address
    always_comb begin
        rd_en = i_cmd.walk_rd | i_cmd.take_rd | i_cmd.head_rd | i_cmd.tail_rd;
        if (i_cmd.walk_rd) begin
            rd_addr = r_idx;
        end else if (i_cmd.take_rd) begin
            rd_addr = r_at;
        end else if (i_cmd.tail_rd) begin
            rd_addr = tail_addr;
        end else begin
            rd_addr = '0;
        end
    end

    // Select the write: a shift transfer or the new value
    always_comb begin
        wr_en   = r_wpend | i_cmd.put;
        wr_addr = r_wpend ? r_wa : r_at;
        wr_data = r_wpend ? r_rdata : r_value;
    end

    // Entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Count, pending shift write and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_wpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wpend <= i_cmd.walk_rd;
            if (i_cmd.commit && r_act) begin
                r_count <= r_ins ? r_count + CW'(1) : r_count - CW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item, walk and captured values
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ins     <= d_ins;
            r_act     <= d_act;
            r_shift   <= d_shift;
            r_status  <= d_status;
            r_value   <= i_item_value;
            r_at      <= AW'(d_at);
            r_removed <= '0;
        end
        if (i_cmd.start_walk) begin
            r_idx <= r_ins ? tail_addr : r_at + AW'(1);
        end else if (i_cmd.walk_rd) begin
            r_idx <= r_ins ? r_idx - AW'(1) : r_idx + AW'(1);
        end
        if (i_cmd.walk_rd) begin
            r_wa <= r_ins ? r_idx + AW'(1) : r_idx - AW'(1);
        end
        if (i_cmd.grab) begin
            r_removed <= r_rdata;
        end
        if (i_cmd.tail_rd) begin
            r_head <= r_rdata;
        end
        if (i_cmd.tail_cap) begin
            r_tail <= r_rdata;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_status  <= r_status;
            r_o_removed <= r_removed;
            r_o_count   <= CNT_W'(r_count);
            r_o_head    <= (r_count == '0) ? '0 : r_head;
            r_o_tail    <= (r_count == '0) ? '0 : r_tail;
        end
    end

    // Status toward the controller
    always_comb begin
        o_stat.act       = r_act;
        o_stat.ins       = r_ins;
        o_stat.shift     = r_shift;
        o_stat.walk_last = r_ins ? (r_idx == r_at) : (r_idx == tail_addr);
        o_stat.out_busy  = r_out_valid & i_out_stall;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_removed_value = r_o_removed;
    assign o_element_count = r_o_count;
    assign o_head_value    = r_o_head;
    assign o_tail_value    = r_o_tail;

    `PDL_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(CAPACITY), "count above capacity")
    `PDL_ASSERT_NOW(a_one_write, r_wpend, !i_cmd.put, "shift write collides with put")
    `PDL_ASSERT_NEXT(a_count_hold, !i_cmd.commit, $stable(r_count), "count moved without commit")

endmodule

// ===== hw/rtl/pdl_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdl_ctrl
// Controller: sequences decode, shift walk, write, count update, head and
// tail fetch and the result transfer.
// ----------------------------------------------------------------------------
module pdl_ctrl
    import pdl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!i_stat.act) begin
                    n_state = S_COMMIT;
                end else if (i_stat.ins) begin
                    if (i_stat.shift) begin
                        o_cmd.start_walk = 1'b1;
                        n_state          = S_SHIFT;
                    end else begin
                        n_state = S_PUT;
                    end
                end else begin
                    o_cmd.take_rd = 1'b1;
                    n_state       = S_GRAB;
                end
            end
            S_GRAB: begin
                o_cmd.grab = 1'b1;
                if (i_stat.shift) begin
                    o_cmd.start_walk = 1'b1;
                    n_state          = S_SHIFT;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_SHIFT: begin
                o_cmd.walk_rd = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last shift write lands here
                n_state = i_stat.ins ? S_PUT : S_COMMIT;
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_HEAD;
            end
            S_HEAD: begin
                o_cmd.head_rd = 1'b1;
                n_state       = S_TAIL;
            end
            S_TAIL: begin
                o_cmd.tail_rd = 1'b1;
                n_state       = S_TCAP;
            end
            S_TCAP: begin
                o_cmd.tail_cap = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for positional_deque_list_top. A short table of
// directed requests covers the empty and bad-position refusals and the
// value extremes. Random requests follow, biased toward filling or draining
// the list. A shadow list in a queue predicts every result, and a monitor
// checks each output transfer field by field. Both sides idle at random, and
// the receiver stalls once for a long stretch.
// ----------------------------------------------------------------------------
module testbench
    import pdl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_CAP       = 64;
    localparam int RAND_PER_PHASE = 630;
    localparam int BIAS_SPAN      = 96;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 100;
    localparam int CYCLE_LIMIT    = 1_000_000;

    // Unused mode codes: the block reports the list unchanged
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    localparam logic signed [VAL_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN  = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_ONES = 32'shFFFF_FFFF;

    typedef struct packed {
        logic        [ST_W-1:0]  status;
        logic signed [VAL_W-1:0] removed;
        logic        [CNT_W-1:0] count;
        logic signed [VAL_W-1:0] head;
        logic signed [VAL_W-1:0] tail;
    } list_result_t;

    // One directed request; fixed marks a typed-in expected result
    typedef struct packed {
        logic        [MODE_W-1:0] mode;
        logic signed [VAL_W-1:0]  value;
        logic        [POS_W-1:0]  pos;
        logic                     fixed;
        list_result_t             res;
    } request_row_t;

    localparam int DIR_N = 24;

    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    i_in_valid      = 1'b0;
    logic       [MODE_W-1:0] i_mode          = '0;
    logic signed [VAL_W-1:0] i_item_value    = '0;
    logic       [POS_W-1:0]  i_position      = '0;
    logic                    i_out_stall     = 1'b0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic       [ST_W-1:0]   o_status;
    logic signed [VAL_W-1:0] o_removed_value;
    logic       [CNT_W-1:0]  o_element_count;
    logic signed [VAL_W-1:0] o_head_value;
    logic signed [VAL_W-1:0] o_tail_value;

    logic signed [VAL_W-1:0] shadow_list [$];
    list_result_t            pending_results [$];
    request_row_t            dir_rows [DIR_N];

    int error_count   = 0;
    int cycle_count   = 0;
    int phase_idx     = 0;
    int recv_idle_pct = 79;
    int send_idle_pct = 37;
    int hold_left     = 0;
    bit pressure_done = 1'b0;

    positional_deque_list_top #(
        .CAPACITY (LIST_CAP)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_item_value    (i_item_value),
        .i_position      (i_position),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_element_count (o_element_count),
        .o_head_value    (o_head_value),
        .o_tail_value    (o_tail_value)
    );

    // Free-running clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Apply one request to the shadow list and return the result it reports
    function automatic list_result_t apply_request(logic [MODE_W-1:0] mode,
                                                   logic signed [VAL_W-1:0] value,
                                                   logic [POS_W-1:0] pos);
        list_result_t res;
        int cnt;
        int at;
        res = '0;
        cnt = shadow_list.size();
        at  = int'(pos) - 1;
        res.status = ST_OK;
        case (mode)
            MODE_INS_HEAD, MODE_INS_TAIL, MODE_INS_POS: begin
                if (cnt >= LIST_CAP) begin
                    res.status = ST_FULL;
                end else if (mode == MODE_INS_HEAD) begin
                    shadow_list.push_front(value);
                end else if (mode == MODE_INS_TAIL) begin
                    shadow_list.push_back(value);
                end else if (at >= 0 && at <= cnt) begin
                    shadow_list.insert(at, value);
                end else begin
                    res.status = ST_RANGE;
                end
            end
            MODE_REM_HEAD, MODE_REM_TAIL, MODE_REM_POS: begin
                if (cnt == 0) begin
                    res.status = ST_EMPTY;
                end else if (mode == MODE_REM_HEAD) begin
                    res.removed = shadow_list.pop_front();
                end else if (mode == MODE_REM_TAIL) begin
                    res.removed = shadow_list.pop_back();
                end else if (at >= 0 && at < cnt) begin
                    res.removed = shadow_list[at];
                    shadow_list.delete(at);
                end else begin
                    res.status = ST_RANGE;
                end
            end
            default: ;
        endcase
        res.count = CNT_W'(shadow_list.size());
        if (shadow_list.size() != 0) begin
            res.head = shadow_list[0];
            res.tail = shadow_list[$];
        end
        return res;
    endfunction

    // Offer one request, hold it until the transfer, then record the expectation
    task automatic offer(logic [MODE_W-1:0] mode, logic signed [VAL_W-1:0] value,
                         logic [POS_W-1:0] pos, logic fixed, list_result_t fixed_res);
        list_result_t pred;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_item_value <= value;
        i_position   <= pos;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = apply_request(mode, value, pos);
        pending_results.push_back(fixed ? fixed_res : pred);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return VAL_ONES;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // Four-state compare so an unknown output never slips through
    function automatic void check_field(string name, logic signed [63:0] want,
                                        logic signed [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Receiver: random stalls, plus one long hold at the start of the last phase
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (phase_idx == 2 && !pressure_done) begin
            i_out_stall   <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            pressure_done <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Check each output transfer against the oldest expectation
    always @(posedge i_clk) begin
        list_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no request outstanding");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, o_status);
                check_field("removed_value", want.removed, o_removed_value);
                check_field("element_count", want.count, o_element_count);
                check_field("head_value", want.head, o_head_value);
                check_field("tail_value", want.tail, o_tail_value);
            end
        end
    end

    // Stimulus
    initial begin
        logic        [MODE_W-1:0] mode;
        logic signed [VAL_W-1:0]  value;
        logic        [POS_W-1:0]  pos;
        int insert_pct;
        int cnt;
        int lim;
        int sel;

        // mode, value, position, typed, {status, removed, count, head, tail}
        dir_rows = '{
            '{MODE_REM_HEAD, 32'sd0,      7'd0,   1'b1, '{ST_EMPTY, 0, 0, 0, 0}},
            '{MODE_REM_TAIL, 32'sd5,      7'd0,   1'b1, '{ST_EMPTY, 0, 0, 0, 0}},
            '{MODE_REM_POS,  32'sd0,      7'd127, 1'b1, '{ST_EMPTY, 0, 0, 0, 0}},
            '{MODE_INS_POS,  32'sd11,     7'd0,   1'b1, '{ST_RANGE, 0, 0, 0, 0}},
            '{MODE_INS_POS,  32'sd12,     7'd2,   1'b1, '{ST_RANGE, 0, 0, 0, 0}},
            '{MODE_INS_POS,  VAL_MAX,     7'd1,   1'b1, '{ST_OK, 0, 1, VAL_MAX, VAL_MAX}},
            '{MODE_INS_HEAD, VAL_MIN,     7'd0,   1'b1, '{ST_OK, 0, 2, VAL_MIN, VAL_MAX}},
            '{MODE_INS_TAIL, VAL_ONES,    7'd127, 1'b1, '{ST_OK, 0, 3, VAL_MIN, VAL_ONES}},
            '{MODE_INS_POS,  32'sd7,      7'd127, 1'b1, '{ST_RANGE, 0, 3, VAL_MIN, VAL_ONES}},
            '{MODE_INS_POS,  32'sd0,      7'd4,   1'b0, '0},
            '{MODE_INS_POS,  32'sh5555_5555, 7'd2, 1'b0, '0},
            '{MODE_REM_POS,  32'sd0,      7'd0,   1'b1, '{ST_RANGE, 0, 5, VAL_MIN, 0}},
            '{MODE_REM_POS,  32'sd0,      7'd6,   1'b1, '{ST_RANGE, 0, 5, VAL_MIN, 0}},
            '{MODE_REM_POS,  32'sd0,      7'd5,   1'b0, '0},
            '{MODE_REM_POS,  32'sd0,      7'd1,   1'b0, '0},
            '{MODE_SPARE_6,  32'sd99,     7'd3,   1'b0, '0},
            '{MODE_SPARE_7,  VAL_MAX,     7'd127, 1'b0, '0},
            '{MODE_REM_POS,  VAL_ONES,    7'd2,   1'b0, '0},
            '{MODE_REM_HEAD, 32'sd0,      7'd0,   1'b0, '0},
            '{MODE_REM_TAIL, 32'sd0,      7'd0,   1'b0, '0},
            '{MODE_REM_TAIL, 32'sd0,      7'd0,   1'b1, '{ST_EMPTY, 0, 0, 0, 0}},
            '{MODE_INS_TAIL, 32'sd1,      7'd0,   1'b0, '0},
            '{MODE_INS_POS,  32'shAAAA_AAAA, 7'd1, 1'b0, '0},
            '{MODE_REM_POS,  32'sd0,      7'd2,   1'b0, '0}
        };

        // Hold reset, then release it
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (dir_rows[k]) begin
            offer(dir_rows[k].mode, dir_rows[k].value, dir_rows[k].pos,
                  dir_rows[k].fixed, dir_rows[k].res);
        end

        // Random phases: sender-light/receiver-heavy, swapped, then no idling
        insert_pct = 50;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 79 : 0;
            recv_idle_pct <= (ph == 0) ? 79 : (ph == 1) ? 37 : 0;
            phase_idx     <= ph;
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                // Swing between filling and draining so both limits are hit
                if (n % BIAS_SPAN == 0) begin
                    case ($urandom_range(0, 2))
                        0:       insert_pct = 85;
                        1:       insert_pct = 15;
                        default: insert_pct = 50;
                    endcase
                end
                cnt   = shadow_list.size();
                value = pick_value();
                sel   = $urandom_range(0, 3);
                if ($urandom_range(0, 99) < 3) begin
                    mode = $urandom_range(0, 1) ? MODE_SPARE_6 : MODE_SPARE_7;
                end else if ($urandom_range(0, 99) < insert_pct) begin
                    mode = (sel == 0) ? MODE_INS_HEAD : (sel == 1) ? MODE_INS_TAIL
                                                                   : MODE_INS_POS;
                end else begin
                    mode = (sel == 0) ? MODE_REM_HEAD : (sel == 1) ? MODE_REM_TAIL
                                                                   : MODE_REM_POS;
                end
                // Mostly legal positions, sometimes zero or past the end
                if (mode == MODE_INS_POS || mode == MODE_REM_POS) begin
                    lim = (mode == MODE_INS_POS) ? cnt + 1 : cnt;
                    if (lim >= 1 && $urandom_range(0, 99) < 85) begin
                        pos = POS_W'($urandom_range(1, lim));
                    end else if ($urandom_range(0, 1) != 0) begin
                        pos = '0;
                    end else begin
                        pos = POS_W'($urandom_range(lim + 1, 127));
                    end
                end else begin
                    pos = POS_W'($urandom_range(0, 127));
                end
                offer(mode, value, pos, 1'b0, '0);
            end
        end
        i_in_valid <= 1'b0;

        // Drain outstanding results, then allow the longest latency to pass
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
